/* hw/rtl/apq_pkg.sv */
// Package for the array priority queue: field widths, command codes,
// sequencer states and the result record. No dependencies.

package apq_pkg;

   localparam int CMD_W          = 2;
   localparam int PAYLOAD_PORT_W = 32;
   localparam int PRIO_W         = 16;
   localparam int COUNT_PORT_W   = 6;

   localparam int DEPTH_DEFAULT         = 32;
   localparam int PAYLOAD_WIDTH_DEFAULT = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT  = 2'd0,
      CMD_EXTRACT = 2'd1,
      CMD_CLEAR   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                             out_valid;
      logic [PAYLOAD_PORT_W-1:0]        out_payload;
      logic signed [PRIO_W-1:0]         out_priority;
      logic                             dropped;
      logic [COUNT_PORT_W-1:0]          entry_count;
      logic                             is_full;
   } rsp_data_type;

endpackage

/* hw/rtl/apq_if.sv */
// Valid/ready channel interfaces for the request and response sides.
// Depends on apq_pkg for the field widths.

interface apq_req_if import apq_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           command;
   logic [PAYLOAD_PORT_W-1:0]  in_payload;
   logic signed [PRIO_W-1:0]   in_priority;

   modport source (output valid, command, in_payload, in_priority, input ready);
   modport sink   (input valid, command, in_payload, in_priority, output ready);
endinterface

interface apq_rsp_if import apq_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       out_valid;
   logic [PAYLOAD_PORT_W-1:0]  out_payload;
   logic signed [PRIO_W-1:0]   out_priority;
   logic                       dropped;
   logic [COUNT_PORT_W-1:0]    entry_count;
   logic                       is_full;

   modport source (output valid, out_valid, out_payload, out_priority, dropped,
                   entry_count, is_full, input ready);
   modport sink   (input valid, out_valid, out_payload, out_priority, dropped,
                   entry_count, is_full, output ready);
endinterface

/* hw/rtl/array_priority_queue.sv */
// Bounded priority queue kept as an unsorted array with a linear max scan.
// Depends on apq_pkg, apq_if and apq_core.
//
// Usage: req_chan carries one command per item (insert, extract highest
// priority, clear); rsp_chan returns exactly one item per command with the
// extracted entry, the drop flag, the entry count and the full flag.
// Both channels use valid/ready; an item moves when both are high.
// Insert, clear, a refused insert and an extract on an empty queue go from
// idle straight to the done state. An extract over n stored entries whose
// winner sits at index b scans all n entries, then moves each entry above b
// down by one through the store's single write port and goes to done; the
// result then passes through the response register to rsp_chan.
// The block takes one item at a time; req_chan.ready is high only while
// the sequencer is idle.
// A response register separates the two sides, so the next request is
// accepted while a response waits; a stalled receiver holds the response
// and, once the next one is finished, holds the sequencer as well.
// Synchronous reset empties the queue and drops any pending response; the
// stored entries themselves are not cleared and need no clearing pass.

module array_priority_queue import apq_pkg::*; #(
   parameter int DEPTH         = DEPTH_DEFAULT,
   parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   apq_req_if.sink   req_chan,
   apq_rsp_if.source rsp_chan
);

   logic         res_valid;
   logic         res_take;
   rsp_data_type res_data;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_ff, rsp_in;

   apq_core #(
      .DEPTH         (DEPTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .command     (req_chan.command),
      .in_payload  (req_chan.in_payload),
      .in_priority (req_chan.in_priority),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res_data    (res_data)
   );

   assign res_take = res_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_in       = res_data;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_valid    = rsp_ff.out_valid;
   assign rsp_chan.out_payload  = rsp_ff.out_payload;
   assign rsp_chan.out_priority = rsp_ff.out_priority;
   assign rsp_chan.dropped      = rsp_ff.dropped;
   assign rsp_chan.entry_count  = rsp_ff.entry_count;
   assign rsp_chan.is_full      = rsp_ff.is_full;

`ifndef SYNTHESIS
   a_drop_only_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.dropped |-> rsp_chan.is_full)
      else $error("A refused insert was reported while the queue was not full.");

   a_extract_leaves_room: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.out_valid |-> !rsp_chan.is_full && !rsp_chan.dropped)
      else $error("An extract reported a full queue or a drop.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("The sequencer accepted two items in consecutive cycles.");
`endif

endmodule

/* hw/rtl/apq_mem.sv */
// Entry store of the priority queue: one write port, one registered read port.
// Depends on nothing beyond its parameters.

module apq_mem #(
   parameter int DEPTH = 32,
   parameter int DW    = 48,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] store_ff [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/apq_core.sv */
// Priority queue sequencer: insert, clear, linear max scan and gap-closing shift
// over the entry store, with one shared priority comparator. Uses apq_pkg, apq_mem.

module apq_core import apq_pkg::*; #(
   parameter int DEPTH         = DEPTH_DEFAULT,
   parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [CMD_W-1:0]          command,
   input  logic [PAYLOAD_PORT_W-1:0] in_payload,
   input  logic signed [PRIO_W-1:0]  in_priority,
   output logic                      res_valid,
   input  logic                      res_take,
   output rsp_data_type              res_data
);

   localparam int SW = (PAYLOAD_WIDTH > PAYLOAD_PORT_W) ? PAYLOAD_PORT_W : PAYLOAD_WIDTH;
   localparam int DW = PRIO_W + SW;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = (CW > COUNT_PORT_W) ? CW : COUNT_PORT_W;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   logic [DW-1:0] best_ff, best_in;
   logic          out_valid_ff, out_valid_in;
   logic [DW-1:0] out_word_ff, out_word_in;
   logic          dropped_ff, dropped_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [DW-1:0] mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [DW-1:0] mem_rdata;

   logic                     accept;
   logic                     full;
   logic                     empty;
   logic                     last_scan;
   logic                     last_shift;
   logic                     take_new;
   logic                     no_shift;
   logic [AW-1:0]            best_idx_nx;
   logic [DW-1:0]            best_nx;
   logic signed [PRIO_W-1:0] rd_prio;
   logic signed [PRIO_W-1:0] best_prio;
   logic [EW-1:0]            count_wide;

   apq_mem #(
      .DEPTH (DEPTH),
      .DW    (DW),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign accept      = req_valid && req_ready;
   assign full        = (count_ff == CW'(DEPTH));
   assign empty       = (count_ff == '0);
   assign rd_prio     = $signed(mem_rdata[DW-1:SW]);
   assign best_prio   = $signed(best_ff[DW-1:SW]);
   assign take_new    = (idx_ff == '0) || (rd_prio > best_prio);
   assign best_idx_nx = take_new ? idx_ff : best_idx_ff;
   assign best_nx     = take_new ? mem_rdata : best_ff;
   assign last_scan   = (CW'(idx_ff) == count_ff - CW'(1));
   assign no_shift    = (CW'(best_idx_nx) == count_ff - CW'(1));
   assign last_shift  = (CW'(idx_ff) == count_ff - CW'(1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((command == CMD_EXTRACT) && !empty) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (last_scan) begin
               state_in = no_shift ? ST_DONE : ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (last_shift) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      res_valid = (state_ff == ST_DONE);
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = mem_rdata;
      mem_raddr = '0;
      unique case (state_ff)
         ST_IDLE: begin
            mem_we    = accept && (command == CMD_INSERT) && !full;
            mem_waddr = count_ff[AW-1:0];
            mem_wdata = {in_priority, in_payload[SW-1:0]};
         end
         ST_SCAN: begin
            mem_raddr = last_scan ? best_idx_nx + AW'(1) : idx_ff + AW'(1);
         end
         ST_SHIFT: begin
            mem_we    = 1'b1;
            mem_raddr = idx_ff + AW'(2);
         end
         default: ;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      dropped_in   = dropped_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               out_valid_in = 1'b0;
               out_word_in  = '0;
               dropped_in   = 1'b0;
               idx_in       = '0;
               best_idx_in  = '0;
               unique case (command)
                  CMD_INSERT: begin
                     if (full) begin
                        dropped_in = 1'b1;
                     end else begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            idx_in      = idx_ff + AW'(1);
            best_idx_in = best_idx_nx;
            best_in     = best_nx;
            if (last_scan) begin
               out_valid_in = 1'b1;
               out_word_in  = best_nx;
               count_in     = count_ff - CW'(1);
               idx_in       = best_idx_nx;
            end
         end
         ST_SHIFT: begin
            idx_in = idx_ff + AW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff       <= idx_in;
      best_idx_ff  <= best_idx_in;
      best_ff      <= best_in;
      out_valid_ff <= out_valid_in;
      out_word_ff  <= out_word_in;
      dropped_ff   <= dropped_in;
   end

   assign count_wide = EW'(count_ff);

   always_comb begin
      res_data.out_valid    = out_valid_ff;
      res_data.out_payload  = PAYLOAD_PORT_W'(out_word_ff[SW-1:0]);
      res_data.out_priority = $signed(out_word_ff[DW-1:SW]);
      res_data.dropped      = dropped_ff;
      res_data.entry_count  = count_wide[COUNT_PORT_W-1:0];
      res_data.is_full      = full;
   end

endmodule
